### sv/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
`default_nettype none

package bba_pkg;

	// Map geometry. WORD_BITS must be a power of two.
	localparam int MAP_BLOCKS = 1024;
	localparam int WORD_BITS  = 32;
	localparam int NWORDS     = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int WIDX_W     = $clog2(NWORDS);

	// Field widths of the transfers.
	localparam int BLOCK_W = 10;

	// Internal width for block numbers, wide enough for any map size and for the field.
	localparam int BN_W  = $clog2(MAP_BLOCKS) + 1;
	localparam int EXT_W = (BN_W > BLOCK_W + 1) ? BN_W : BLOCK_W + 1;

	// Reset value of map word 0: blocks 0 and 1 are used.
	localparam logic [WORD_BITS-1:0] RESET_WORD0 = WORD_BITS'(3);

	// Bits of the last word that map real blocks; the rest always read as used.
	localparam int LAST_BITS = MAP_BLOCKS - (NWORDS - 1) * WORD_BITS;
	localparam logic [WORD_BITS-1:0] ALL_ONES  = '1;
	localparam logic [WORD_BITS-1:0] LAST_MASK = ALL_ONES >> (WORD_BITS - LAST_BITS);

	// Request codes.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Status codes.
	localparam logic ST_DONE = 1'b0;
	localparam logic ST_FULL = 1'b1;

	// Depth of the command queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic               req_type;
		logic [BLOCK_W-1:0] block_id;
	} req_t;

	typedef struct packed {
		logic [BLOCK_W-1:0] alloc_block;
		logic               status;
	} rsp_t;

	// Classified command handed from front to back.
	typedef struct packed {
		logic              is_free;
		logic              in_range;
		logic [WIDX_W-1:0] widx;
		logic [BIT_W-1:0]  bidx;
	} cmd_t;

endpackage

`default_nettype wire

### sv/bba_front.sv
// Front end: takes requests, classifies them and pushes commands into the queue.
`default_nettype none

module bba_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  bba_pkg::req_t      req,
	output logic               push,
	output bba_pkg::cmd_t      push_cmd,
	input  wire logic          q_full
);

	logic                       valid_s1;
	bba_pkg::cmd_t              cmd_s1;
	bba_pkg::cmd_t              cmd_d;
	logic [bba_pkg::EXT_W-1:0]  bid_ext;
	logic                       take;

	// Split a free request into word and bit, and check it against the map size.
	always_comb begin
		bid_ext = bba_pkg::EXT_W'(req.block_id);
		cmd_d.is_free = (req.req_type == bba_pkg::REQ_FREE);
		cmd_d.in_range = (bid_ext < bba_pkg::EXT_W'(bba_pkg::MAP_BLOCKS));
		if (cmd_d.is_free) begin
			cmd_d.widx = bid_ext[bba_pkg::BIT_W +: bba_pkg::WIDX_W];
			cmd_d.bidx = bid_ext[bba_pkg::BIT_W-1:0];
		end else begin
			cmd_d.widx = '0;
			cmd_d.bidx = '0;
		end
	end

	// The stage hands its command on whenever the queue has room.
	assign push      = valid_s1 && !q_full;
	assign push_cmd  = cmd_s1;
	assign req_stall = valid_s1 && !push;
	assign take      = req_valid && !req_stall;

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

`default_nettype wire

### sv/bba_fifo.sv
// Short command queue that decouples the front end from the map engine.
`default_nettype none

module bba_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  bba_pkg::cmd_t      push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output bba_pkg::cmd_t      head
);

	bba_pkg::cmd_t               entry_q [bba_pkg::QDEPTH];
	logic [bba_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [bba_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [bba_pkg::QCNT_W-1:0]  cnt_q;

	assign full      = (cnt_q == bba_pkg::QCNT_W'(bba_pkg::QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bba_pkg::QPTR_W'(bba_pkg::QDEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bba_pkg::QPTR_W'(bba_pkg::QDEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

### sv/bba_back.sv
// Map engine: holds the free map, runs allocate scans and frees, drives the results.
`default_nettype none

module bba_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  bba_pkg::cmd_t      cmd,
	output logic               pop,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output bba_pkg::rsp_t      rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0]                     state_q;
	bba_pkg::cmd_t                  cur_q;
	logic [bba_pkg::WIDX_W-1:0]     widx_q;
	logic [bba_pkg::WORD_BITS-1:0]  map_q [bba_pkg::NWORDS];
	bba_pkg::rsp_t                  res_q;
	logic                           out_valid_q;
	bba_pkg::rsp_t                  out_q;

	logic [bba_pkg::WORD_BITS-1:0]  word;
	logic                           word_full;
	logic [bba_pkg::BIT_W-1:0]      free_bit;
	logic [bba_pkg::EXT_W-1:0]      blk_ext;
	logic                           last_word;
	logic                           slot_free;

	// Current map word, with the bits past the last block shown as used.
	always_comb begin
		word = map_q[widx_q];
		last_word = (widx_q == bba_pkg::WIDX_W'(bba_pkg::NWORDS - 1));
		if (last_word) begin
			word = word | ~bba_pkg::LAST_MASK;
		end
		word_full = (word == bba_pkg::ALL_ONES);
	end

	// Lowest clear bit of the word.
	always_comb begin
		free_bit = '0;
		for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				free_bit = bba_pkg::BIT_W'(i);
			end
		end
		blk_ext = (bba_pkg::EXT_W'(widx_q) << bba_pkg::BIT_W) | bba_pkg::EXT_W'(free_bit);
	end

	assign slot_free = !out_valid_q || !rsp_stall;
	assign pop       = (state_q == ST_IDLE) && cmd_valid;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Sequencer: take a command, do one map word per cycle, then hand off the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			widx_q      <= '0;
			for (int i = 0; i < bba_pkg::NWORDS; i++) begin
				map_q[i] <= (i == 0) ? bba_pkg::RESET_WORD0 : '0;
			end
		end else begin
			// The output register fills from the engine or empties on a transfer.
			if (state_q == ST_RESP && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						widx_q  <= cmd.widx;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cur_q.is_free) begin
						if (cur_q.in_range) begin
							map_q[widx_q][cur_q.bidx] <= 1'b0;
						end
						state_q <= ST_RESP;
					end else if (!word_full) begin
						map_q[widx_q][free_bit] <= 1'b1;
						state_q <= ST_RESP;
					end else if (last_word) begin
						state_q <= ST_RESP;
					end else begin
						widx_q <= widx_q + 1'b1;
					end
				end
				ST_RESP: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command and result payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= cmd;
		end
		if (state_q == ST_EXEC) begin
			if (cur_q.is_free) begin
				res_q.alloc_block <= '0;
				res_q.status      <= bba_pkg::ST_DONE;
			end else if (!word_full) begin
				res_q.alloc_block <= blk_ext[bba_pkg::BLOCK_W-1:0];
				res_q.status      <= bba_pkg::ST_DONE;
			end else begin
				res_q.alloc_block <= '0;
				res_q.status      <= bba_pkg::ST_FULL;
			end
		end
		if (state_q == ST_RESP && slot_free) begin
			out_q <= res_q;
		end
	end

endmodule

`default_nettype wire

### sv/bitmap_block_allocator.sv
// Top level of the first-fit bitmap block allocator.
`default_nettype none

// The allocator keeps one used bit per storage block in a map of 32-bit words; after
// reset blocks 0 and 1 are marked used. An allocate request returns the lowest free
// block and marks it used, or block 0 with the full status when none is left. A free
// request clears the bit of its block (numbers past the map are ignored) and returns
// block 0 with status done. Every request gives exactly one result transfer, in
// request order. Requests pass through a classifying stage and a two-entry queue, so
// up to three can be taken while the map engine is busy. The engine reads one map
// word per cycle: a free works on its own word only, an allocate scans from word 0
// up to the first word with a clear bit. Results sit in an output register, so the
// engine goes on with the next request while a finished result waits to be taken.
module bitmap_block_allocator (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  bba_pkg::req_t      req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output bba_pkg::rsp_t      rsp
);

	logic           push;
	bba_pkg::cmd_t  push_cmd;
	logic           q_full;
	logic           pop;
	logic           q_not_empty;
	bba_pkg::cmd_t  q_head;

	// Request intake and classification.
	bba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full)
	);

	// Command queue.
	bba_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Map engine and result register.
	bba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (q_head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the first-fit bitmap block allocator.
`timescale 1ns / 100ps

module tb;

	// Tracks the used map as the block should hold it and queues the result that
	// each accepted request must produce.
	class block_map_model;
		logic [bba_pkg::WORD_BITS-1:0] used_words [bba_pkg::NWORDS];
		bba_pkg::rsp_t                 expected_q [$];
		int                            error_count;

		function new();
			foreach (used_words[i])
				used_words[i] = '0;
			// Blocks 0 and 1 come out of reset marked used.
			used_words[0] = bba_pkg::WORD_BITS'(3);
			error_count = 0;
		endfunction

		// Applies an accepted request to the map and queues its result.
		function void note_request(bba_pkg::req_t r);
			bba_pkg::rsp_t exp;
			int            w;
			int            b;
			int            blk;
			bit            found;
			exp.alloc_block = '0;
			exp.status      = bba_pkg::ST_DONE;
			if (r.req_type == bba_pkg::REQ_FREE) begin
				blk = int'(r.block_id);
				if (blk < bba_pkg::MAP_BLOCKS)
					used_words[blk / bba_pkg::WORD_BITS][blk % bba_pkg::WORD_BITS] = 1'b0;
			end else begin
				found = 0;
				// First fit: lowest word that is not all ones, then its lowest clear bit.
				for (w = 0; w < bba_pkg::NWORDS && !found; w++) begin
					if (used_words[w] != '1) begin
						for (b = 0; b < bba_pkg::WORD_BITS && !found; b++) begin
							blk = w * bba_pkg::WORD_BITS + b;
							if (blk < bba_pkg::MAP_BLOCKS && !used_words[w][b]) begin
								used_words[w][b] = 1'b1;
								exp.alloc_block  = bba_pkg::BLOCK_W'(blk);
								found            = 1;
							end
						end
					end
				end
				if (!found)
					exp.status = bba_pkg::ST_FULL;
			end
			expected_q.push_back(exp);
		endfunction

		// Compares a result transfer with the oldest queued result.
		function void check_result(bba_pkg::rsp_t got);
			bba_pkg::rsp_t exp;
			if (expected_q.size() == 0) begin
				$error("unexpected result: alloc_block %0d status %0d", got.alloc_block,
					got.status);
				error_count++;
			end else begin
				exp = expected_q.pop_front();
				if (got.alloc_block !== exp.alloc_block) begin
					$error("alloc_block: expected %0d, got %0d", exp.alloc_block,
						got.alloc_block);
					error_count++;
				end
				if (got.status !== exp.status) begin
					$error("status: expected %0d, got %0d", exp.status, got.status);
					error_count++;
				end
			end
		endfunction

		// Returns a block that is currently used, or a random one when none is, so that frees hit live blocks.
		function int pick_used_block();
			int start;
			int k;
			int blk;
			start = $urandom_range(0, bba_pkg::MAP_BLOCKS - 1);
			for (k = 0; k < bba_pkg::MAP_BLOCKS; k++) begin
				blk = (start + k) % bba_pkg::MAP_BLOCKS;
				if (used_words[blk / bba_pkg::WORD_BITS][blk % bba_pkg::WORD_BITS])
					return blk;
			end
			return start;
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	bba_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	bba_pkg::rsp_t rsp;

	block_map_model map_model;
	int             results_seen;
	bit             quiet_tail;
	bit             hold_off_done;

	bitmap_block_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog for a hung run.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Offers one request and holds it until the transfer happens.
	task automatic send_request(input bba_pkg::req_t r);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		map_model.note_request(r);
	endtask

	task automatic send_alloc(input logic [bba_pkg::BLOCK_W-1:0] id);
		bba_pkg::req_t r;
		r.req_type = bba_pkg::REQ_ALLOC;
		r.block_id = id;
		send_request(r);
	endtask

	task automatic send_free(input logic [bba_pkg::BLOCK_W-1:0] id);
		bba_pkg::req_t r;
		r.req_type = bba_pkg::REQ_FREE;
		r.block_id = id;
		send_request(r);
	endtask

	// Random request: allocate with the given percentage, otherwise free either a
	// live block or any block number.
	function automatic bba_pkg::req_t random_request(input int alloc_pct);
		bba_pkg::req_t r;
		if ($urandom_range(0, 99) < alloc_pct) begin
			r.req_type = bba_pkg::REQ_ALLOC;
			r.block_id = bba_pkg::BLOCK_W'($urandom);
		end else begin
			r.req_type = bba_pkg::REQ_FREE;
			if ($urandom_range(0, 1) == 0)
				r.block_id = bba_pkg::BLOCK_W'(map_model.pick_used_block());
			else
				r.block_id = bba_pkg::BLOCK_W'($urandom);
		end
		return r;
	endfunction

	// Receiver: checks each result transfer and stalls in random bursts, with one
	// long hold-off early on so that the block backs up into its input.
	initial begin
		int stall_left;
		rsp_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				map_model.check_result(rsp);
				results_seen++;
			end
			if (stall_left > 0)
				stall_left--;
			else if (!hold_off_done && results_seen >= 150) begin
				stall_left    = 120;
				hold_off_done = 1;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 9);
			rsp_stall <= (stall_left > 0);
		end
	end

	// Reset, stimulus and end of run.
	initial begin
		int i;
		map_model     = new();
		results_seen  = 0;
		quiet_tail    = 0;
		hold_off_done = 0;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: first fit, reuse of freed blocks, freeing the reserved
		// blocks, freeing free blocks and the extremes of block_id.
		send_alloc('0);
		send_alloc('1);
		send_free(10'd2);
		send_alloc(10'h2AA);
		send_free(10'd0);
		send_free(10'd1);
		send_alloc(10'h155);
		send_alloc('0);
		send_alloc('1);
		send_free(10'd1023);
		send_free(10'd1023);
		send_free(10'd512);
		send_free(10'd3);
		send_free(10'd0);
		send_alloc('0);
		send_alloc('0);
		send_free(10'h155);
		send_free(10'h2AA);
		send_alloc('1);
		send_free(10'd31);
		send_free(10'd32);
		send_alloc('0);

		// Random part: a mixed stretch, a stretch that fills the map and keeps it
		// near full, then a stretch that drains it, with no idling at the end.
		for (i = 0; i < 1600; i++) begin
			if (i == 1400)
				quiet_tail = 1;
			if (i < 400)
				send_request(random_request(50));
			else if (i < 1300)
				send_request(random_request(96));
			else
				send_request(random_request(35));
		end
		req_valid <= 1'b0;

		while (map_model.expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (map_model.error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
